>>> rtl/md5_pkg.sv
// md5 digest package: item types, queue control structs, round tables and helpers
`default_nettype none

package md5_pkg;

  localparam int unsigned NumSlots = 2;
  localparam int unsigned SlotW    = 1;
  localparam int unsigned WordIdxW = 4;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;

  // word positions of the bit length inside the last block, its byte position and the last round
  localparam logic [WordIdxW-1:0] LenLoIdx = 4'd14;
  localparam logic [WordIdxW-1:0] LenHiIdx = 4'd15;
  localparam logic [5:0]          LenPos   = 6'd56;
  localparam logic [5:0]          LastRnd  = 6'd63;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
    logic       no_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
  } out_item_t;

  // front to block queue
  typedef struct packed {
    logic                wr_en;
    logic [SlotW-1:0]    slot;
    logic [WordIdxW-1:0] word_idx;
    logic [31:0]         word;
    logic                commit;
    logic                last_blk;
  } qwr_t;

  // block queue status
  typedef struct packed {
    logic [NumSlots-1:0] busy;
    logic [NumSlots-1:0] last_blk;
  } qstat_t;

  // back to block queue
  typedef struct packed {
    logic             rel;
    logic [SlotW-1:0] slot;
  } qrel_t;

  localparam logic [31:0] KTab [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
    logic [4:0] s;
    unique case ({rnd[5:4], rnd[1:0]})
      4'h0: s = 5'd7;
      4'h1: s = 5'd12;
      4'h2: s = 5'd17;
      4'h3: s = 5'd22;
      4'h4: s = 5'd5;
      4'h5: s = 5'd9;
      4'h6: s = 5'd14;
      4'h7: s = 5'd20;
      4'h8: s = 5'd4;
      4'h9: s = 5'd11;
      4'ha: s = 5'd16;
      4'hb: s = 5'd23;
      4'hc: s = 5'd6;
      4'hd: s = 5'd10;
      4'he: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [WordIdxW-1:0] msg_idx(input logic [5:0] rnd);
    logic [3:0] v;
    logic [3:0] g;
    v = rnd[3:0];
    unique case (rnd[5:4])
      2'd0: g = v;
      2'd1: g = 4'(v * 4'd5 + 4'd1);
      2'd2: g = 4'(v * 4'd3 + 4'd5);
      default: g = 4'(v * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    unique case (grp)
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

`default_nettype wire

>>> rtl/md5_front.sv
// md5 digest front: packs message bytes into words, pads and appends the bit length
`default_nettype none

module md5_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  input  wire md5_pkg::in_item_t in_item_i,
  output logic                   full,
  input  wire md5_pkg::qstat_t   qstat_i,
  output md5_pkg::qwr_t          qwr_o
);

  localparam logic ST_BYTES = 1'b0;
  localparam logic ST_PAD   = 1'b1;

  logic                              st_q, st_d;
  logic [63:0]                       cnt_q, cnt_d;
  logic [31:0]                       word_q, word_d;
  logic [md5_pkg::SlotW-1:0]         slot_q, slot_d;
  logic [md5_pkg::WordIdxW-1:0]      widx_q, widx_d;
  logic                              first_q, first_d;
  logic                              len_blk_q, len_blk_d;

  logic        slot_free;
  logic        acc;
  logic [1:0]  lane;
  logic [31:0] word_new;
  logic [31:0] pad_word;
  logic [63:0] nxt_cnt;
  logic [63:0] bit_len;

  assign slot_free = !qstat_i.busy[slot_q];
  assign full      = !((st_q == ST_BYTES) && slot_free);
  assign acc       = push && !full;
  assign lane      = cnt_q[1:0];
  assign bit_len   = {cnt_q[60:0], 3'b000};

  always_comb begin
    word_new = word_q;
    word_new[{lane, 3'b000} +: 8] = in_item_i.data_byte;
  end

  // first pad word keeps the bytes already taken, then the pad marker, then zeros
  always_comb begin
    pad_word = '0;
    if (first_q) begin
      for (int l = 0; l < 4; l++) begin
        if (2'(l) < lane) begin
          pad_word[8*l +: 8] = word_q[8*l +: 8];
        end else if (2'(l) == lane) begin
          pad_word[8*l +: 8] = md5_pkg::PadByte;
        end
      end
    end else if (len_blk_q && (widx_q == md5_pkg::LenLoIdx)) begin
      pad_word = bit_len[31:0];
    end else if (len_blk_q && (widx_q == md5_pkg::LenHiIdx)) begin
      pad_word = bit_len[63:32];
    end
  end

  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    word_d    = word_q;
    slot_d    = slot_q;
    widx_d    = widx_q;
    first_d   = first_q;
    len_blk_d = len_blk_q;
    qwr_o     = '0;
    qwr_o.slot = slot_q;
    nxt_cnt   = in_item_i.no_byte ? cnt_q : cnt_q + 64'd1;

    unique case (st_q)
      ST_BYTES: begin
        if (acc) begin
          if (!in_item_i.no_byte) begin
            word_d = word_new;
            cnt_d  = nxt_cnt;
            if (lane == 2'd3) begin
              qwr_o.wr_en    = 1'b1;
              qwr_o.word_idx = cnt_q[5:2];
              qwr_o.word     = word_new;
            end
            if (cnt_q[5:0] == 6'h3f) begin
              qwr_o.commit   = 1'b1;
              qwr_o.last_blk = 1'b0;
              slot_d         = ~slot_q;
            end
          end
          if (in_item_i.is_last) begin
            st_d      = ST_PAD;
            first_d   = 1'b1;
            widx_d    = nxt_cnt[5:2];
            len_blk_d = (nxt_cnt[5:0] < md5_pkg::LenPos);
          end
        end
      end
      ST_PAD: begin
        if (slot_free) begin
          qwr_o.wr_en    = 1'b1;
          qwr_o.word_idx = widx_q;
          qwr_o.word     = pad_word;
          first_d        = 1'b0;
          widx_d         = widx_q + 4'd1;
          if (widx_q == md5_pkg::LenHiIdx) begin
            qwr_o.commit   = 1'b1;
            qwr_o.last_blk = len_blk_q;
            slot_d         = ~slot_q;
            if (len_blk_q) begin
              st_d  = ST_BYTES;
              cnt_d = '0;
            end else begin
              len_blk_d = 1'b1;
            end
          end
        end
      end
      default: st_d = ST_BYTES;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_BYTES;
      cnt_q     <= '0;
      slot_q    <= '0;
      widx_q    <= '0;
      first_q   <= 1'b0;
      len_blk_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      slot_q    <= slot_d;
      widx_q    <= widx_d;
      first_q   <= first_d;
      len_blk_q <= len_blk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

`default_nettype wire

>>> rtl/md5_blkq.sv
// md5 digest block queue: two 16-word block slots between front and round engine
`default_nettype none

module md5_blkq (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire md5_pkg::qwr_t                       qwr_i,
  input  wire md5_pkg::qrel_t                      qrel_i,
  input  wire logic [md5_pkg::SlotW-1:0]           rd_slot_i,
  input  wire logic [md5_pkg::WordIdxW-1:0]        rd_idx_i,
  output logic [31:0]                              rd_word_o,
  output md5_pkg::qstat_t                          qstat_o
);

  logic [31:0] mem_q [md5_pkg::NumSlots][16];
  logic [31:0] rd_word_q;
  logic [md5_pkg::NumSlots-1:0] busy_q, busy_d;
  logic [md5_pkg::NumSlots-1:0] last_q, last_d;

  always_ff @(posedge clk_i) begin
    if (qwr_i.wr_en) begin
      mem_q[qwr_i.slot][qwr_i.word_idx] <= qwr_i.word;
    end
    rd_word_q <= mem_q[rd_slot_i][rd_idx_i];
  end

  assign rd_word_o        = rd_word_q;
  assign qstat_o.busy     = busy_q;
  assign qstat_o.last_blk = last_q;

  always_comb begin
    busy_d = busy_q;
    last_d = last_q;
    if (qwr_i.commit) begin
      busy_d[qwr_i.slot] = 1'b1;
      last_d[qwr_i.slot] = qwr_i.last_blk;
    end
    if (qrel_i.rel) begin
      busy_d[qrel_i.slot] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      last_q <= '0;
    end else begin
      busy_q <= busy_d;
      last_q <= last_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/md5_back.sv
// md5 digest back: round engine, chaining words and result register
`default_nettype none

module md5_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire md5_pkg::qstat_t               qstat_i,
  input  wire logic [31:0]                   rd_word_i,
  output logic [md5_pkg::SlotW-1:0]          rd_slot_o,
  output logic [md5_pkg::WordIdxW-1:0]       rd_idx_o,
  output md5_pkg::qrel_t                     qrel_o,
  output logic                               empty,
  input  wire logic                          pop,
  output md5_pkg::out_item_t                 out_item_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                st_q, st_d;
  logic [5:0]                rnd_q, rnd_d;
  logic [md5_pkg::SlotW-1:0] slot_q, slot_d;
  logic [31:0]               a_q, b_q, c_q, d_q;
  logic [31:0]               a_d, b_d, c_d, d_d;
  logic [31:0]               pre_q, pre_d;
  logic [3:0][31:0]          chain_q, chain_d;
  md5_pkg::out_item_t        out_q, out_d;
  logic                      out_vld_q, out_vld_d;

  logic        start;
  logic [5:0]  nxt_rnd;
  logic [5:0]  rd_rnd;
  logic [31:0] pre_base;
  logic [31:0] pre_k;
  logic [31:0] pre_sum;
  logic [31:0] f_sum;
  logic [31:0] new_b;
  logic [3:0][31:0] sums;

  assign start = (st_q == ST_IDLE) && qstat_i.busy[slot_q] &&
                 (!qstat_i.last_blk[slot_q] || !out_vld_q);
  assign nxt_rnd   = (st_q == ST_RUN) ? rnd_q + 6'd1 : 6'd0;
  // message word read is registered, so the address runs two rounds ahead
  assign rd_rnd    = (st_q == ST_RUN) ? rnd_q + 6'd2 : {5'd0, start};
  assign rd_slot_o = (st_q == ST_DONE) ? ~slot_q : slot_q;
  assign rd_idx_o  = md5_pkg::msg_idx(rd_rnd);
  assign pre_k     = md5_pkg::KTab[nxt_rnd];
  assign pre_base  = (st_q == ST_RUN) ? d_q : chain_q[0];
  // next round's a, sine constant and message word, one round ahead
  assign pre_sum   = pre_base + pre_k + rd_word_i;
  assign f_sum     = md5_pkg::round_f(rnd_q[5:4], b_q, c_q, d_q) + pre_q;
  assign new_b     = b_q + md5_pkg::rotl(f_sum, md5_pkg::rot_amt(rnd_q));

  assign sums[0] = chain_q[0] + a_q;
  assign sums[1] = chain_q[1] + b_q;
  assign sums[2] = chain_q[2] + c_q;
  assign sums[3] = chain_q[3] + d_q;

  assign empty      = !out_vld_q;
  assign out_item_o = out_q;

  always_comb begin
    st_d      = st_q;
    rnd_d     = rnd_q;
    slot_d    = slot_q;
    a_d       = a_q;
    b_d       = b_q;
    c_d       = c_q;
    d_d       = d_q;
    pre_d     = pre_q;
    chain_d   = chain_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    qrel_o    = '0;
    qrel_o.slot = slot_q;

    if (pop && out_vld_q) begin
      out_vld_d = 1'b0;
    end

    unique case (st_q)
      ST_IDLE: begin
        if (start) begin
          a_d   = chain_q[0];
          b_d   = chain_q[1];
          c_d   = chain_q[2];
          d_d   = chain_q[3];
          pre_d = pre_sum;
          rnd_d = '0;
          st_d  = ST_RUN;
        end
      end
      ST_RUN: begin
        a_d   = d_q;
        b_d   = new_b;
        c_d   = b_q;
        d_d   = c_q;
        pre_d = pre_sum;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == md5_pkg::LastRnd) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        qrel_o.rel = 1'b1;
        slot_d     = ~slot_q;
        st_d       = ST_IDLE;
        if (qstat_i.last_blk[slot_q]) begin
          out_d.digest_a = sums[0];
          out_d.digest_b = sums[1];
          out_d.digest_c = sums[2];
          out_d.digest_d = sums[3];
          out_vld_d      = 1'b1;
          chain_d        = {md5_pkg::InitD, md5_pkg::InitC, md5_pkg::InitB, md5_pkg::InitA};
        end else begin
          chain_d = sums;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      rnd_q     <= '0;
      slot_q    <= '0;
      chain_q   <= {md5_pkg::InitD, md5_pkg::InitC, md5_pkg::InitB, md5_pkg::InitA};
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      rnd_q     <= rnd_d;
      slot_q    <= slot_d;
      chain_q   <= chain_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    pre_q <= pre_d;
    out_q <= out_d;
  end

endmodule

`default_nettype wire

>>> rtl/md5_message_digest.sv
// md5 digest top level: byte front, block queue and round engine
//
//   channel   | direction | handshake          | item
//   ----------+-----------+--------------------+------------------------------------
//   input     | in        | push / full        | data_byte, is_last, no_byte
//   result    | out       | pop / empty        | digest_a .. digest_d
//
// one byte per cycle while the front is not padding and a block slot is free; two slots
// let bytes of the next block flow in while the engine works. the engine works through
// each block as a load, 64 rounds at one round per cycle, and the chain update.
// after the last item the front writes padding one word per cycle while a slot is free,
// up to 16 words per pad block (one or two blocks); the digest shows once the engine has
// run the final block's rounds and chain update.
// reset needs no clearing pass; result stalls hold the digest and block only the next
// final block from starting.
`default_nettype none

module md5_message_digest (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  input  wire md5_pkg::in_item_t   in_item_i,
  output logic                     full,
  output logic                     empty,
  input  wire logic                pop,
  output md5_pkg::out_item_t       out_item_o
);

  md5_pkg::qwr_t                   qwr;
  md5_pkg::qrel_t                  qrel;
  md5_pkg::qstat_t                 qstat;
  logic [md5_pkg::SlotW-1:0]       rd_slot;
  logic [md5_pkg::WordIdxW-1:0]    rd_idx;
  logic [31:0]                     rd_word;

  md5_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .in_item_i (in_item_i),
    .full      (full),
    .qstat_i   (qstat),
    .qwr_o     (qwr)
  );

  md5_blkq u_blkq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .qwr_i     (qwr),
    .qrel_i    (qrel),
    .rd_slot_i (rd_slot),
    .rd_idx_i  (rd_idx),
    .rd_word_o (rd_word),
    .qstat_o   (qstat)
  );

  md5_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .qstat_i    (qstat),
    .rd_word_i  (rd_word),
    .rd_slot_o  (rd_slot),
    .rd_idx_o   (rd_idx),
    .qrel_o     (qrel),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

>>> rtl/md5_chk.sv
// md5 digest port checker and its bind to the top level
`default_nettype none

module md5_chk (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               push,
  input wire md5_pkg::in_item_t  in_item_i,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire md5_pkg::out_item_t out_item_o
);

  // a waiting result stays put until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result item dropped before pop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(out_item_o))
    else $error("result item changed while waiting");

  // the front goes into padding after a last item and takes nothing then
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full && in_item_i.is_last |=> full)
    else $error("item taken during padding");

endmodule

bind md5_message_digest md5_chk u_md5_chk (.*);

`default_nettype wire

>>> tb/sv/md5_digest_checker.sv
// md5 digest checker: predicts digests from accepted items and compares popped results
module md5_digest_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  logic                full,
  input  md5_pkg::in_item_t   in_item_i,
  input  logic                empty,
  input  logic                pop,
  input  md5_pkg::out_item_t  out_item_o,
  output int                  errors,
  output int                  pending,
  output int                  digests_checked
);

  logic [7:0]  blk_bytes [64];
  logic [31:0] chain [4];
  logic [63:0] byte_total;
  logic [31:0] sine_tab [64];
  int unsigned rot_tab [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
  md5_pkg::out_item_t digests_due [$];

  initial begin : build_sine
    real s;
    int i;
    for (i = 0; i < 64; i++) begin
      s = $sin(i + 1);
      if (s < 0.0) s = -s;
      sine_tab[i] = 32'(longint'($floor(s * 4294967296.0)));
    end
  end

  function automatic void start_chain();
    chain[0] = 32'h67452301;
    chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe;
    chain[3] = 32'h10325476;
    byte_total = '0;
  endfunction

  function automatic void fold_block();
    logic [31:0] a, b, c, d, f, m, t;
    int r, g, sh, p;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      p = 4 * g;
      m = {blk_bytes[p + 3], blk_bytes[p + 2], blk_bytes[p + 1], blk_bytes[p]};
      t = f + a + sine_tab[r] + m;
      sh = rot_tab[(r / 16) * 4 + r % 4];
      t = (t << sh) | (t >> (32 - sh));
      a = d;
      d = c;
      c = b;
      b = b + t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
  endfunction

  function automatic void absorb_item(md5_pkg::in_item_t it);
    md5_pkg::out_item_t dig;
    logic [63:0] bits;
    int pos, i;
    if (!it.no_byte) begin
      blk_bytes[byte_total[5:0]] = it.data_byte;
      byte_total++;
      if (byte_total[5:0] == 6'd0) fold_block();
    end
    if (it.is_last) begin
      pos = int'(byte_total[5:0]);
      blk_bytes[pos] = 8'h80;
      pos++;
      // length no longer fits, pad out an extra block
      if (pos > 56) begin
        while (pos < 64) begin
          blk_bytes[pos] = 8'h00;
          pos++;
        end
        fold_block();
        pos = 0;
      end
      while (pos < 56) begin
        blk_bytes[pos] = 8'h00;
        pos++;
      end
      bits = byte_total << 3;
      for (i = 0; i < 8; i++) blk_bytes[56 + i] = bits[8 * i +: 8];
      fold_block();
      dig.digest_a = chain[0];
      dig.digest_b = chain[1];
      dig.digest_c = chain[2];
      dig.digest_d = chain[3];
      digests_due.push_back(dig);
      start_chain();
    end
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch %s: expected %08h got %08h", what, want, got);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    md5_pkg::out_item_t want;
    if (!rst_ni) begin
      start_chain();
      digests_due.delete();
      errors = 0;
      pending = 0;
      digests_checked = 0;
    end else begin
      if (pop && !empty) begin
        if (digests_due.size() == 0) begin
          note_mismatch("digest with none due, digest_a", 32'h0, out_item_o.digest_a);
        end else begin
          want = digests_due.pop_front();
          digests_checked++;
          if (out_item_o.digest_a !== want.digest_a)
            note_mismatch("digest_a", want.digest_a, out_item_o.digest_a);
          if (out_item_o.digest_b !== want.digest_b)
            note_mismatch("digest_b", want.digest_b, out_item_o.digest_b);
          if (out_item_o.digest_c !== want.digest_c)
            note_mismatch("digest_c", want.digest_c, out_item_o.digest_c);
          if (out_item_o.digest_d !== want.digest_d)
            note_mismatch("digest_d", want.digest_d, out_item_o.digest_d);
        end
      end
      if (push && !full) absorb_item(in_item_i);
      pending = digests_due.size();
    end
  end

endmodule

>>> tb/sv/tb_md5_message_digest.sv
// md5 digest testbench top: clock, reset, message stimulus, result drain and verdict
module tb_md5_message_digest;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic               empty;
  logic               pop;
  md5_pkg::in_item_t  in_item;
  md5_pkg::out_item_t out_item;

  int errors;
  int pending;
  int digests_checked;
  int items_sent = 0;
  int messages_sent = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int boundary_lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 121, 128};

  always #1 clk_i = ~clk_i;

  md5_message_digest DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_item_i  (in_item),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  md5_digest_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .in_item_i       (in_item),
    .empty           (empty),
    .pop             (pop),
    .out_item_o      (out_item),
    .errors          (errors),
    .pending         (pending),
    .digests_checked (digests_checked)
  );

  task automatic offer_item(input logic [7:0] data, input logic last, input logic no_byte);
    md5_pkg::in_item_t it;
    int gap;
    it.data_byte = data;
    it.is_last   = last;
    it.no_byte   = no_byte;
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
    if (last) messages_sent++;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_message(input int len, input bit last_has_byte);
    int i;
    for (i = 0; i < len; i++) begin
      // stray empty items between bytes
      if ($urandom_range(0, 9) == 0) offer_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      offer_item(8'($urandom_range(0, 255)), (i == len - 1) && last_has_byte, 1'b0);
    end
    if (len == 0 || !last_has_byte) offer_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  function automatic int pick_len();
    int len;
    case ($urandom_range(0, 9))
      0: len = 0;
      1: len = boundary_lens[$urandom_range(0, 9)];
      2: len = $urandom_range(65, 200);
      default: len = $urandom_range(1, 54);
    endcase
    return len;
  endfunction

  initial begin : result_side
    int n;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // long stall so the block backs up and pushes back on input
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (800) @(negedge clk_i);
      end else if (!calm && $urandom_range(0, 9) < 2) begin
        n = $urandom_range(1, 12);
        pop <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int i;
    rst_ni  = 1'b0;
    push    = 1'b0;
    in_item = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed messages
    offer_item(8'hff, 1'b1, 1'b1);
    offer_item(8'h5a, 1'b0, 1'b1);
    offer_item(8'hff, 1'b1, 1'b0);
    offer_item(8'h00, 1'b1, 1'b0);
    offer_item(8'h61, 1'b0, 1'b0);
    offer_item(8'h62, 1'b0, 1'b0);
    offer_item(8'h63, 1'b1, 1'b0);
    offer_item(8'h80, 1'b0, 1'b0);
    offer_item(8'h3c, 1'b0, 1'b1);
    offer_item(8'h7f, 1'b0, 1'b0);
    offer_item(8'h00, 1'b1, 1'b1);
    offer_item(8'haa, 1'b1, 1'b1);

    hold_req = 1'b1;
    for (i = 0; i < 10; i++) send_message(boundary_lens[i], i[0]);
    while (items_sent < 1800) begin
      if (items_sent >= 1500) calm = 1'b1;
      send_message(pick_len(), 1'($urandom_range(0, 1)));
    end
    push <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
    $display("covered %0d items in %0d messages, boundary lengths and empty messages",
             items_sent, messages_sent);
    $display("%0d digests compared, %0d mismatches", digests_checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("PASS md5_message_digest");
    end else begin
      $display("FAIL md5_message_digest");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("FAIL md5_message_digest");
    $finish;
  end

endmodule

>>> md5_message_digest.f
rtl/md5_pkg.sv
rtl/md5_front.sv
rtl/md5_blkq.sv
rtl/md5_back.sv
rtl/md5_message_digest.sv
rtl/md5_chk.sv
tb/sv/md5_digest_checker.sv
tb/sv/tb_md5_message_digest.sv
